// ----- rtl/ntg_pkg.sv -----
`default_nettype none
package ntg_pkg;

    // Fixed field widths
    localparam int ID_W       = 8;
    localparam int ID_IDX_W   = $clog2(ID_W);
    localparam int DRAW_W     = 16;
    localparam int THR_W      = 17;
    localparam int SIDE_W     = 5;
    localparam int FLIT_W     = 11;
    localparam int LIMIT_W    = 32;
    localparam int PKT_W      = 32;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Mesh geometry
    localparam int MAX_SIDE  = 16;
    localparam int NODE_BITS = 8;
    localparam int N_W       = ID_W + 1;
    localparam int NBITS_W   = $clog2(N_W) + 1;
    localparam int DIV_CNT_W = $clog2(ID_W);

    // Default sequence counter width
    localparam int COUNT_BITS = 32;

    localparam logic [ID_W-1:0] NODE_MASK =
        (NODE_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << NODE_BITS) - 1);

    // Destination pattern codes
    typedef enum logic [MODE_W-1:0] {
        PAT_UNIFORM    = 3'd0,
        PAT_TRANSPOSE1 = 3'd1,
        PAT_TRANSPOSE2 = 3'd2,
        PAT_BITREV     = 3'd3,
        PAT_SHUFFLE    = 3'd4,
        PAT_BUTTERFLY  = 3'd5,
        PAT_SELF_A     = 3'd6,
        PAT_SELF_B     = 3'd7
    } pattern_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_WIDTH     = 3'd2,
        REG_HEIGHT    = 3'd3,
        REG_FLITS     = 3'd4,
        REG_LIMIT     = 3'd5,
        REG_LIMIT_EN  = 3'd6,
        REG_GEN_EN    = 3'd7
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_MAP
    } state_t;

    typedef struct packed {
        logic              start;
        logic [ID_W-1:0]   dividend;
        logic [N_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [ID_W-1:0]   quotient;
        logic [N_W-1:0]    remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SIDE_W-1:0]  width;
        logic [SIDE_W-1:0]  height;
        logic [NBITS_W-1:0] nbits;
    } dest_cfg_t;

    // Force a mesh side into 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIDE_W'(1);
        end
        else if (s > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

    // Smallest k with 2^k >= n
    function automatic logic [NBITS_W-1:0] ceil_log2(input logic [N_W-1:0] n);
        logic [NBITS_W-1:0] r;
        r = NBITS_W'(N_W - 1);
        for (int k = N_W - 2; k >= 0; k--) begin
            if ((N_W'(1) << k) >= n) begin
                r = NBITS_W'(k);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ntg_divider.sv -----
`default_nettype none
module ntg_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ntg_pkg::div_req_t req,
    output ntg_pkg::div_rsp_t      rsp
);

    localparam int DVD_W = ntg_pkg::ID_W;
    localparam int DVS_W = ntg_pkg::N_W;
    localparam int CNT_W = ntg_pkg::DIV_CNT_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic             last_step;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign last_step = (cnt_reg == CNT_W'(DVD_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

    // Checks
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last_step) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule
`default_nettype wire

// ----- rtl/ntg_dest.sv -----
`default_nettype none
module ntg_dest (
    input  wire ntg_pkg::dest_cfg_t              cfg,
    input  wire logic [ntg_pkg::ID_W-1:0]        id,
    input  wire logic [ntg_pkg::ID_W-1:0]        quot,
    input  wire logic [ntg_pkg::N_W-1:0]         remd,
    output logic [ntg_pkg::ID_W-1:0]             dest
);

    localparam int ID_W    = ntg_pkg::ID_W;
    localparam int SIDE_W  = ntg_pkg::SIDE_W;
    localparam int NBITS_W = ntg_pkg::NBITS_W;
    localparam int IX_W    = ntg_pkg::ID_IDX_W;
    localparam int PROD_W  = 2 * SIDE_W;

    logic [SIDE_W-1:0]  x, y, tx, ty;
    logic [PROD_W-1:0]  t1, t2;
    logic [NBITS_W-1:0] top_idx;
    logic [NBITS_W-1:0] rev_idx;
    logic [ID_W-1:0]    d;

    // Coordinates: remainder is x, quotient is y
    assign x       = remd[SIDE_W-1:0];
    assign y       = quot[SIDE_W-1:0];
    assign tx      = cfg.width - SIDE_W'(1) - x;
    assign ty      = cfg.height - SIDE_W'(1) - y;
    assign t1      = PROD_W'(tx) * PROD_W'(cfg.width) + PROD_W'(ty);
    assign t2      = PROD_W'(x) * PROD_W'(cfg.width) + PROD_W'(y);
    assign top_idx = cfg.nbits - NBITS_W'(1);

    // Select destination by pattern
    always_comb
    begin
        d       = id;
        rev_idx = '0;
        case (cfg.mode)
            ntg_pkg::PAT_UNIFORM:    d = remd[ID_W-1:0];
            ntg_pkg::PAT_TRANSPOSE1: d = t1[ID_W-1:0];
            ntg_pkg::PAT_TRANSPOSE2: d = t2[ID_W-1:0];
            ntg_pkg::PAT_BITREV:
            begin
                for (int i = 0; i < ID_W; i++)
                begin
                    if (NBITS_W'(i) < cfg.nbits)
                    begin
                        rev_idx = top_idx - NBITS_W'(i);
                        d[i]    = id[rev_idx[IX_W-1:0]];
                    end
                end
            end
            ntg_pkg::PAT_SHUFFLE:
            begin
                if (cfg.nbits != '0)
                begin
                    for (int i = 0; i < ID_W - 1; i++)
                    begin
                        if (NBITS_W'(i + 1) < cfg.nbits)
                        begin
                            d[i+1] = id[i];
                        end
                    end
                    d[0] = id[top_idx[IX_W-1:0]];
                end
            end
            ntg_pkg::PAT_BUTTERFLY:
            begin
                if (cfg.nbits != '0)
                begin
                    d[0]                 = id[top_idx[IX_W-1:0]];
                    d[top_idx[IX_W-1:0]] = id[0];
                end
            end
            default: d = id;
        endcase
    end

    assign dest = d & ntg_pkg::NODE_MASK;

endmodule
`default_nettype wire

// ----- rtl/noc_synthetic_traffic_generator.sv -----
`default_nettype none
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid / in_ready  | source_node, inject_draw, random_dest
// out      | output    | out_valid / out_ready| packet_number, from_node, to_node,
//          |           |                      | packet_flits
// cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// An injecting item keeps in_ready low through setup, eight shift-subtract steps
// of the shared divider (node by width, or random destination by node count), done, map.
// A miss passes only through setup before in_ready returns high for the next item.
// The output register lets a new item start while a packet waits; mapping stalls until
// that register frees. Reset clears the counter and stopped flag and reloads config defaults.
module noc_synthetic_traffic_generator #(
    parameter int COUNT_BITS = ntg_pkg::COUNT_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ntg_pkg::ID_W-1:0]        source_node,
    input  wire logic [ntg_pkg::DRAW_W-1:0]      inject_draw,
    input  wire logic [ntg_pkg::ID_W-1:0]        random_dest,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [ntg_pkg::PKT_W-1:0]            packet_number,
    output logic [ntg_pkg::ID_W-1:0]             from_node,
    output logic [ntg_pkg::ID_W-1:0]             to_node,
    output logic [ntg_pkg::FLIT_W-1:0]           packet_flits,
    input  wire logic                            cfg_we,
    input  wire logic [ntg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ntg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ID_W    = ntg_pkg::ID_W;
    localparam int SIDE_W  = ntg_pkg::SIDE_W;
    localparam int N_W     = ntg_pkg::N_W;
    localparam int NBITS_W = ntg_pkg::NBITS_W;
    localparam int LIMIT_W = ntg_pkg::LIMIT_W;
    localparam int PKT_W   = ntg_pkg::PKT_W;
    localparam int CMP_W   = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam int EXT_W   = (CMP_W > PKT_W) ? CMP_W : PKT_W;

    // Configuration registers
    logic [ntg_pkg::MODE_W-1:0]  cfg_mode_reg;
    logic [ntg_pkg::THR_W-1:0]   cfg_thr_reg;
    logic [SIDE_W-1:0]           cfg_width_reg;
    logic [SIDE_W-1:0]           cfg_height_reg;
    logic [ntg_pkg::FLIT_W-1:0]  cfg_flits_reg;
    logic [LIMIT_W-1:0]          cfg_limit_reg;
    logic                        cfg_limit_en_reg;
    logic                        cfg_gen_en_reg;

    ntg_pkg::state_t             state_reg, state_next;
    logic [COUNT_BITS-1:0]       seq_reg, seq_next;
    logic                        stopped_reg, stopped_next;
    logic                        out_valid_reg, out_valid_next;

    logic [ID_W-1:0]             src_reg, rnd_reg;
    logic [ntg_pkg::DRAW_W-1:0]  draw_reg;
    logic [SIDE_W-1:0]           w_reg, h_reg;
    logic [NBITS_W-1:0]          nbits_reg;

    logic [PKT_W-1:0]            pkt_num_reg;
    logic [ID_W-1:0]             from_reg, to_reg;
    logic [ntg_pkg::FLIT_W-1:0]  flits_reg;

    logic [SIDE_W-1:0]           w_c, h_c;
    logic [2*SIDE_W-1:0]         prod_c;
    logic [N_W-1:0]              n_c;
    logic [NBITS_W-1:0]          nbits_c;
    logic [COUNT_BITS-1:0]       seq_inc;
    logic [CMP_W-1:0]            lim_ext, seq_ext, inc_ext;
    logic [EXT_W-1:0]            seq_pkt;
    logic                        stop_pre, stop_post, hit;
    logic                        accept, load_out;

    ntg_pkg::div_req_t           div_req;
    ntg_pkg::div_rsp_t           div_rsp;
    ntg_pkg::dest_cfg_t          dcfg;
    logic [ID_W-1:0]             dest;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ntg_pkg::ST_IDLE);
    assign load_out = (state_reg == ntg_pkg::ST_MAP) && (!out_valid_reg || out_ready);

    // Mesh geometry from the configured sides
    assign w_c     = ntg_pkg::clamp_side(cfg_width_reg);
    assign h_c     = ntg_pkg::clamp_side(cfg_height_reg);
    assign prod_c  = (2*SIDE_W)'(w_c) * (2*SIDE_W)'(h_c);
    assign n_c     = prod_c[N_W-1:0];
    assign nbits_c = ntg_pkg::ceil_log2(n_c);

    // Packet limit tests before and after the count advances
    assign seq_inc   = seq_reg + COUNT_BITS'(1);
    assign lim_ext   = CMP_W'(cfg_limit_reg);
    assign seq_ext   = CMP_W'(seq_reg);
    assign inc_ext   = CMP_W'(seq_inc);
    assign seq_pkt   = EXT_W'(seq_reg);
    assign stop_pre  = stopped_reg || (cfg_limit_en_reg && (seq_ext >= lim_ext));
    assign stop_post = stopped_reg || (cfg_limit_en_reg && (inc_ext >= lim_ext));
    assign hit       = cfg_gen_en_reg && !stop_pre && ({1'b0, src_reg} < n_c) &&
                       ({1'b0, draw_reg} < cfg_thr_reg);

    // Divider request: uniform mode reduces the random destination by the node count
    always_comb
    begin
        div_req.start = (state_reg == ntg_pkg::ST_SETUP) && hit;
        if (cfg_mode_reg == ntg_pkg::PAT_UNIFORM)
        begin
            div_req.dividend = rnd_reg;
            div_req.divisor  = n_c;
        end
        else
        begin
            div_req.dividend = src_reg;
            div_req.divisor  = N_W'(w_c);
        end
    end

    ntg_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign dcfg.mode   = cfg_mode_reg;
    assign dcfg.width  = w_reg;
    assign dcfg.height = h_reg;
    assign dcfg.nbits  = nbits_reg;

    ntg_dest u_dest (
        .cfg  (dcfg),
        .id   (src_reg),
        .quot (div_rsp.quotient),
        .remd (div_rsp.remainder),
        .dest (dest)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        stopped_next   = stopped_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ntg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ntg_pkg::ST_SETUP;
                end
            end
            ntg_pkg::ST_SETUP:
            begin
                stopped_next = stop_pre;
                state_next   = hit ? ntg_pkg::ST_DIVIDE : ntg_pkg::ST_IDLE;
            end
            ntg_pkg::ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ntg_pkg::ST_MAP;
                end
            end
            ntg_pkg::ST_MAP:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    seq_next       = seq_inc;
                    stopped_next   = stop_post;
                    state_next     = ntg_pkg::ST_IDLE;
                end
            end
            default: state_next = ntg_pkg::ST_IDLE;
        endcase
    end

    // Hold state, counter and configuration under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ntg_pkg::ST_IDLE;
            seq_reg          <= '0;
            stopped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            cfg_mode_reg     <= '0;
            cfg_thr_reg      <= '0;
            cfg_width_reg    <= SIDE_W'(4);
            cfg_height_reg   <= SIDE_W'(4);
            cfg_flits_reg    <= ntg_pkg::FLIT_W'(5);
            cfg_limit_reg    <= '0;
            cfg_limit_en_reg <= 1'b0;
            cfg_gen_en_reg   <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (ntg_pkg::cfg_reg_t'(cfg_index))
                    ntg_pkg::REG_MODE:      cfg_mode_reg     <= cfg_data[ntg_pkg::MODE_W-1:0];
                    ntg_pkg::REG_THRESHOLD: cfg_thr_reg      <= cfg_data[ntg_pkg::THR_W-1:0];
                    ntg_pkg::REG_WIDTH:     cfg_width_reg    <= cfg_data[SIDE_W-1:0];
                    ntg_pkg::REG_HEIGHT:    cfg_height_reg   <= cfg_data[SIDE_W-1:0];
                    ntg_pkg::REG_FLITS:     cfg_flits_reg    <= cfg_data[ntg_pkg::FLIT_W-1:0];
                    ntg_pkg::REG_LIMIT:     cfg_limit_reg    <= cfg_data[LIMIT_W-1:0];
                    ntg_pkg::REG_LIMIT_EN:  cfg_limit_en_reg <= cfg_data[0];
                    ntg_pkg::REG_GEN_EN:    cfg_gen_en_reg   <= cfg_data[0];
                    default:                cfg_mode_reg     <= cfg_mode_reg;
                endcase
            end
        end
    end

    // Capture the item, the geometry and the packet
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg  <= source_node;
            draw_reg <= inject_draw;
            rnd_reg  <= random_dest;
        end
        if (state_reg == ntg_pkg::ST_SETUP)
        begin
            w_reg     <= w_c;
            h_reg     <= h_c;
            nbits_reg <= nbits_c;
        end
        if (load_out)
        begin
            pkt_num_reg <= seq_pkt[PKT_W-1:0];
            from_reg    <= src_reg;
            to_reg      <= dest;
            flits_reg   <= cfg_flits_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign packet_number = pkt_num_reg;
    assign from_node     = from_reg;
    assign to_node       = to_reg;
    assign packet_flits  = flits_reg;

    // Checks
    a_count_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (seq_reg == $past(seq_inc)))
        else $error("sequence counter did not advance with a packet");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared");

    a_map_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ntg_pkg::ST_MAP) |-> !stopped_reg)
        else $error("packet mapped after generation stopped");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int ID_W       = ntg_pkg::ID_W;
    localparam int DRAW_W     = ntg_pkg::DRAW_W;
    localparam int THR_W      = ntg_pkg::THR_W;
    localparam int SIDE_W     = ntg_pkg::SIDE_W;
    localparam int FLIT_W     = ntg_pkg::FLIT_W;
    localparam int LIMIT_W    = ntg_pkg::LIMIT_W;
    localparam int PKT_W      = ntg_pkg::PKT_W;
    localparam int MODE_W     = ntg_pkg::MODE_W;
    localparam int CFG_DATA_W = ntg_pkg::CFG_DATA_W;
    localparam int MAX_SIDE   = ntg_pkg::MAX_SIDE;
    localparam int COUNT_BITS = ntg_pkg::COUNT_BITS;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 500;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 110;
    localparam int PHASE_COUNT  = 11;
    localparam int PRESSURE_PH  = 5;
    localparam int STEADY_PH    = 7;
    localparam logic [THR_W-1:0] FULL_RATE = THR_W'(65536);

    typedef struct packed {
        logic [ID_W-1:0]   src;
        logic [DRAW_W-1:0] draw;
        logic [ID_W-1:0]   rnd;
    } offer_t;

    typedef struct packed {
        logic [PKT_W-1:0]  number;
        logic [ID_W-1:0]   src_id;
        logic [ID_W-1:0]   dst_id;
        logic [FLIT_W-1:0] flits;
    } packet_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ID_W-1:0]       source_node = '0;
    logic [DRAW_W-1:0]     inject_draw = '0;
    logic [ID_W-1:0]       random_dest = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PKT_W-1:0]      packet_number;
    logic [ID_W-1:0]       from_node;
    logic [ID_W-1:0]       to_node;
    logic [FLIT_W-1:0]     packet_flits;
    logic                  cfg_we = 1'b0;
    ntg_pkg::cfg_reg_t     cfg_index = ntg_pkg::REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    noc_synthetic_traffic_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .source_node   (source_node),
        .inject_draw   (inject_draw),
        .random_dest   (random_dest),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_number (packet_number),
        .from_node     (from_node),
        .to_node       (to_node),
        .packet_flits  (packet_flits),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the generator configuration and state
    ntg_pkg::pattern_t     gen_mode;
    logic [THR_W-1:0]      gen_thr;
    logic [SIDE_W-1:0]     gen_width;
    logic [SIDE_W-1:0]     gen_height;
    logic [FLIT_W-1:0]     gen_flits;
    logic [LIMIT_W-1:0]    gen_limit;
    logic                  gen_limit_en;
    logic                  gen_on;
    logic [COUNT_BITS-1:0] gen_seq;
    logic                  gen_stopped;

    offer_t  offer_q[$];
    packet_t expected_pkts[$];
    offer_t  next_offer;
    packet_t want_pkt;
    packet_t got_pkt;

    logic        in_taken    = 1'b0;
    int unsigned in_gap      = 0;
    int unsigned out_gap     = 0;
    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;
    logic        pressure_arm = 1'b0;
    logic        steady      = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;
    int unsigned items_taken = 0;
    int unsigned pkts_seen   = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic int unsigned side_of(logic [SIDE_W-1:0] s);
        if (s == '0)
            return 1;
        if (s > SIDE_W'(MAX_SIDE))
            return MAX_SIDE;
        return s;
    endfunction

    function automatic int unsigned node_total();
        return side_of(gen_width) * side_of(gen_height);
    endfunction

    function automatic logic limit_reached();
        return gen_limit_en && (gen_seq >= COUNT_BITS'(gen_limit));
    endfunction

    // Destination for one source under the current pattern
    function automatic logic [ID_W-1:0] route_dest(int unsigned id, int unsigned rnd);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned x;
        int unsigned y;
        int unsigned nb;
        logic [31:0] s;
        logic [31:0] d;
        w = side_of(gen_width);
        h = side_of(gen_height);
        n = w * h;
        x = id % w;
        y = id / w;
        s = id;
        d = id;
        nb = 0;
        while (nb < 31 && (32'd1 << nb) < n)
            nb++;
        case (gen_mode)
            ntg_pkg::PAT_UNIFORM:    d = rnd % n;
            ntg_pkg::PAT_TRANSPOSE1: d = (w - 1 - x) * w + (h - 1 - y);
            ntg_pkg::PAT_TRANSPOSE2: d = x * w + y;
            ntg_pkg::PAT_BITREV:
            begin
                for (int i = 0; i < nb; i++)
                    d[i] = s[nb - 1 - i];
            end
            ntg_pkg::PAT_SHUFFLE:
            begin
                if (nb > 0)
                begin
                    for (int i = 0; i + 1 < nb; i++)
                        d[i + 1] = s[i];
                    d[0] = s[nb - 1];
                end
            end
            ntg_pkg::PAT_BUTTERFLY:
            begin
                if (nb > 0)
                begin
                    d[0] = s[nb - 1];
                    d[nb - 1] = s[0];
                end
            end
            default: d = id;
        endcase
        return d[ID_W-1:0];
    endfunction

    // Work out the packet, if any, that one injection opportunity produces
    task automatic predict_injection(offer_t it);
        packet_t p;
        if (limit_reached())
            gen_stopped = 1'b1;
        if (gen_on && !gen_stopped && it.src < node_total() && it.draw < gen_thr)
        begin
            p.number = gen_seq[PKT_W-1:0];
            p.src_id = it.src;
            p.dst_id = route_dest(it.src, it.rnd);
            p.flits  = gen_flits;
            expected_pkts.insert(expected_pkts.size(), p);
            gen_seq = gen_seq + 1'b1;
        end
        if (limit_reached())
            gen_stopped = 1'b1;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_side();
        if ($urandom_range(99) < 85)
            return $urandom_range(MAX_SIDE, 1);
        if ($urandom_range(1) == 0)
            return 0;
        return $urandom_range(31, MAX_SIDE + 1);
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // Sender: present the next item once the previous one is taken
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (offer_q.size() != 0)
            begin
                next_offer = offer_q.pop_front();
                in_valid <= 1'b1;
                source_node <= next_offer.src;
                inject_draw <= next_offer.draw;
                random_dest <= next_offer.rnd;
                in_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once when the pressure phase arms it
    always @(negedge clk)
    begin
        if (pressure_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random ready gaps, forced low during the hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
        end
        else if (out_gap != 0)
        begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            out_gap <= pick_gap();
        end
    end

    // Accept items into the predictor and check each delivered packet
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_injection({source_node, inject_draw, random_dest});
            items_taken++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got_pkt = {packet_number, from_node, to_node, packet_flits};
            pkts_seen++;
            if (expected_pkts.size() == 0)
            begin
                note_failure($sformatf("unexpected packet num=%0d from=%0d to=%0d flits=%0d",
                    got_pkt.number, got_pkt.src_id, got_pkt.dst_id, got_pkt.flits));
            end
            else
            begin
                want_pkt = expected_pkts.pop_front();
                if (got_pkt.number !== want_pkt.number || got_pkt.src_id !== want_pkt.src_id
                    || got_pkt.dst_id !== want_pkt.dst_id || got_pkt.flits !== want_pkt.flits)
                    note_failure($sformatf({"exp num=%0d from=%0d to=%0d flits=%0d, ",
                        "got num=%0d from=%0d to=%0d flits=%0d"},
                        want_pkt.number, want_pkt.src_id, want_pkt.dst_id, want_pkt.flits,
                        got_pkt.number, got_pkt.src_id, got_pkt.dst_id, got_pkt.flits));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(ntg_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            ntg_pkg::REG_MODE:      gen_mode = ntg_pkg::pattern_t'(val[MODE_W-1:0]);
            ntg_pkg::REG_THRESHOLD: gen_thr = val[THR_W-1:0];
            ntg_pkg::REG_WIDTH:     gen_width = val[SIDE_W-1:0];
            ntg_pkg::REG_HEIGHT:    gen_height = val[SIDE_W-1:0];
            ntg_pkg::REG_FLITS:     gen_flits = val[FLIT_W-1:0];
            ntg_pkg::REG_LIMIT:     gen_limit = val[LIMIT_W-1:0];
            ntg_pkg::REG_LIMIT_EN:  gen_limit_en = val[0];
            ntg_pkg::REG_GEN_EN:    gen_on = val[0];
            default:                gen_on = gen_on;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_offer(int unsigned src, int unsigned draw, int unsigned rnd);
        offer_t it;
        it.src = src;
        it.draw = draw;
        it.rnd = rnd;
        offer_q.insert(offer_q.size(), it);
    endtask

    // Mostly sources inside the mesh, the rest anywhere in the node range
    task automatic queue_random(int unsigned count, int unsigned inside_pct);
        int unsigned src;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < inside_pct)
                src = $urandom_range(node_total() - 1, 0);
            else
                src = $urandom_range(255);
            add_offer(src, $urandom_range(65535), $urandom_range(255));
        end
    endtask

    // Hold until no item is pending or in flight, then let the block settle
    task automatic wait_idle();
        @(posedge clk);
        while (offer_q.size() != 0 || in_valid || expected_pkts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_setup(int unsigned phase);
        int unsigned r;
        logic [CFG_DATA_W-1:0] v;
        if (phase < 8)
            write_reg(ntg_pkg::REG_MODE, phase);
        else
            write_reg(ntg_pkg::REG_MODE, $urandom_range(7));
        r = $urandom_range(99);
        if (r < 5)
            v = 0;
        else if (r < 25)
            v = 65536;
        else
            v = $urandom_range(65536);
        write_reg(ntg_pkg::REG_THRESHOLD, v);
        write_reg(ntg_pkg::REG_WIDTH, pick_side());
        write_reg(ntg_pkg::REG_HEIGHT, pick_side());
        r = $urandom_range(9);
        if (r == 0)
            v = 1;
        else if (r == 1)
            v = 1024;
        else
            v = $urandom_range(1024, 1);
        write_reg(ntg_pkg::REG_FLITS, v);
        // Keep any active limit well clear of this phase
        r = $urandom_range(2);
        if (r == 0)
        begin
            write_reg(ntg_pkg::REG_LIMIT, 32'hFFFF_FFFF);
            write_reg(ntg_pkg::REG_LIMIT_EN, 1);
        end
        else if (r == 1)
        begin
            write_reg(ntg_pkg::REG_LIMIT, gen_seq + 32'd500 + $urandom_range(1000));
            write_reg(ntg_pkg::REG_LIMIT_EN, 1);
        end
        else
        begin
            write_reg(ntg_pkg::REG_LIMIT, $urandom);
            write_reg(ntg_pkg::REG_LIMIT_EN, 0);
        end
        write_reg(ntg_pkg::REG_GEN_EN, $urandom_range(9) != 0);
    endtask

    initial
    begin
        gen_mode = ntg_pkg::PAT_UNIFORM;
        gen_thr = '0;
        gen_width = SIDE_W'(4);
        gen_height = SIDE_W'(4);
        gen_flits = FLIT_W'(5);
        gen_limit = '0;
        gen_limit_en = 1'b0;
        gen_on = 1'b1;
        gen_seq = '0;
        gen_stopped = 1'b0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: a zero threshold never injects
        add_offer(0, 0, 0);
        wait_idle();

        // Full rate on the default 4x4 mesh, extremes of every field
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_UNIFORM);
        write_reg(ntg_pkg::REG_THRESHOLD, 65536);
        write_reg(ntg_pkg::REG_WIDTH, 4);
        write_reg(ntg_pkg::REG_HEIGHT, 4);
        write_reg(ntg_pkg::REG_FLITS, 1024);
        write_reg(ntg_pkg::REG_LIMIT, 32'hFFFF_FFFF);
        write_reg(ntg_pkg::REG_LIMIT_EN, 1);
        write_reg(ntg_pkg::REG_GEN_EN, 1);
        add_offer(0, 0, 255);
        add_offer(15, 65535, 0);
        add_offer(16, 0, 0);
        add_offer(255, 0, 7);
        wait_idle();

        // One item under every other pattern
        for (int m = 1; m < 8; m++)
        begin
            write_reg(ntg_pkg::REG_MODE, m);
            add_offer($urandom_range(15), 0, $urandom_range(255));
            wait_idle();
        end

        // Zero width and oversized height clamp to a 1x16 mesh
        write_reg(ntg_pkg::REG_WIDTH, 0);
        write_reg(ntg_pkg::REG_HEIGHT, 31);
        write_reg(ntg_pkg::REG_FLITS, 1);
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_TRANSPOSE1);
        add_offer(5, 0, 0);
        add_offer(16, 0, 0);
        wait_idle();

        // Non-square transpose lands past the node count
        write_reg(ntg_pkg::REG_WIDTH, 8);
        write_reg(ntg_pkg::REG_HEIGHT, 2);
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_TRANSPOSE2);
        add_offer(15, 100, 0);
        add_offer(9, 0, 0);
        wait_idle();

        // Single-node mesh: bit patterns and uniform all return the source
        write_reg(ntg_pkg::REG_WIDTH, 1);
        write_reg(ntg_pkg::REG_HEIGHT, 1);
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_BITREV);
        add_offer(0, 0, 0);
        wait_idle();
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_SHUFFLE);
        add_offer(0, 0, 0);
        wait_idle();
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_BUTTERFLY);
        add_offer(0, 0, 0);
        wait_idle();
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_UNIFORM);
        add_offer(0, 0, 200);
        wait_idle();

        // Largest mesh, all 256 nodes valid
        write_reg(ntg_pkg::REG_WIDTH, 16);
        write_reg(ntg_pkg::REG_HEIGHT, 16);
        write_reg(ntg_pkg::REG_MODE, ntg_pkg::PAT_BITREV);
        add_offer(255, 0, 0);
        add_offer(1, 65535, 0);
        wait_idle();

        // Lowest nonzero rate: only a zero draw injects
        write_reg(ntg_pkg::REG_THRESHOLD, 1);
        add_offer(3, 0, 0);
        add_offer(3, 1, 0);
        wait_idle();

        // Disabled generator drops everything
        write_reg(ntg_pkg::REG_GEN_EN, 0);
        add_offer(3, 0, 0);
        wait_idle();

        // Random phases, one with a long output stall and one without idling
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            random_setup(ph);
            steady = (ph == STEADY_PH);
            if (ph == PRESSURE_PH)
            begin
                write_reg(ntg_pkg::REG_THRESHOLD, FULL_RATE);
                write_reg(ntg_pkg::REG_GEN_EN, 1);
                pressure_arm = 1'b1;
            end
            queue_random(PHASE_ITEMS, 80);
            wait_idle();
        end
        steady = 1'b0;

        // Packet limit: a few more packets, then generation stops for good
        write_reg(ntg_pkg::REG_MODE, $urandom_range(7));
        write_reg(ntg_pkg::REG_THRESHOLD, 65536);
        write_reg(ntg_pkg::REG_GEN_EN, 1);
        write_reg(ntg_pkg::REG_LIMIT, gen_seq + 32'd5);
        write_reg(ntg_pkg::REG_LIMIT_EN, 1);
        queue_random(30, 100);
        wait_idle();

        // Raising or dropping the limit does not restart generation
        write_reg(ntg_pkg::REG_LIMIT, 32'hFFFF_FFFF);
        queue_random(10, 100);
        wait_idle();
        write_reg(ntg_pkg::REG_LIMIT_EN, 0);
        write_reg(ntg_pkg::REG_LIMIT, 0);
        queue_random(10, 100);
        wait_idle();

        $display("run covered %0d injection opportunities and %0d delivered packets",
            items_taken, pkts_seen);
        $display("over all eight patterns, clamped and single-node meshes, a stall and a limit stop");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
